/* design/sicc_pkg.sv */
// Shared types and constants for the shell input completeness check.
// Used by sicc_state and shell_input_completeness_check; no dependencies.

package sicc_pkg;

    // Width of every signed depth and keyword balance.
    localparam int LEVEL_BITS = 8;

    typedef logic signed [LEVEL_BITS-1:0] t_level;

    localparam t_level LVL_MAX = t_level'({1'b0, {(LEVEL_BITS-1){1'b1}}});
    localparam t_level LVL_MIN = t_level'({1'b1, {(LEVEL_BITS-1){1'b0}}});

    // Byte codes the scanner reacts to.
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_WS_LO  = 8'h09;
    localparam logic [7:0] CH_WS_HI  = 8'h0D;

    // Keywords, first byte in the low bits.
    localparam logic [31:0] KW_DO   = 32'h0000_6F64;
    localparam logic [31:0] KW_IF   = 32'h0000_6669;
    localparam logic [31:0] KW_FI   = 32'h0000_6966;
    localparam logic [31:0] KW_DONE = 32'h656E_6F64;
    localparam logic [31:0] KW_CASE = 32'h6573_6163;
    localparam logic [31:0] KW_ESAC = 32'h6361_7365;

    // One item handed from the input register to the state logic.
    typedef struct packed {
        logic       fire;
        logic [7:0] char_code;
        logic       has_char;
        logic       last;
    } t_step;

    // Verdict for a finished text.
    typedef struct packed {
        logic complete;
        logic saturated;
    } t_result;

endpackage

/* design/sicc_state.sv */
// Running scan state of the completeness check: quoting, depths, token
// tracking and keyword balances. Depends on sicc_pkg.

module sicc_state (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sicc_pkg::t_step  i_step,
    output sicc_pkg::t_result o_result
);

    typedef enum logic [3:0] {
        PH_LEAD  = 4'b0001,
        PH_WORD  = 4'b0010,
        PH_TRAIL = 4'b0100,
        PH_DEAD  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic             sat;
        sicc_pkg::t_level val;
    } t_lvl_res;

    function automatic t_lvl_res lvl_add(input sicc_pkg::t_level v, input logic up);
        t_lvl_res r;
        r.sat = 1'b0;
        r.val = v;
        if (up) begin
            if (v == sicc_pkg::LVL_MAX) r.sat = 1'b1;
            else r.val = v + sicc_pkg::t_level'(1);
        end else begin
            if (v == sicc_pkg::LVL_MIN) r.sat = 1'b1;
            else r.val = v - sicc_pkg::t_level'(1);
        end
        return r;
    endfunction

    logic             r_esc, n_esc;
    logic             r_sq, n_sq;
    logic             r_dq, n_dq;
    sicc_pkg::t_level r_paren, n_paren;
    sicc_pkg::t_level r_brace, n_brace;
    logic [31:0]      r_chars, n_chars;
    logic [2:0]       r_len, n_len;
    t_phase           r_phase, n_phase;
    sicc_pkg::t_level r_loop, n_loop;
    sicc_pkg::t_level r_cond, n_cond;
    sicc_pkg::t_level r_case, n_case;
    logic             r_seen, n_seen;

    logic        c_space;
    logic        c_ws;
    logic        do_fin;
    logic [31:0] f_chars;
    logic [2:0]  f_len;
    t_phase      f_phase;
    t_lvl_res    lv;
    logic [7:0]  ch;

    always_comb begin
        ch      = i_step.char_code;
        n_esc   = r_esc;
        n_sq    = r_sq;
        n_dq    = r_dq;
        n_paren = r_paren;
        n_brace = r_brace;
        n_chars = r_chars;
        n_len   = r_len;
        n_phase = r_phase;
        n_loop  = r_loop;
        n_cond  = r_cond;
        n_case  = r_case;
        n_seen  = r_seen;
        lv      = '0;
        c_space = i_step.has_char && (ch == sicc_pkg::CH_SPACE);
        c_ws    = ch inside {[sicc_pkg::CH_WS_LO:sicc_pkg::CH_WS_HI]};

        // quote and bracket scan
        if (i_step.has_char) begin
            if (r_esc) begin
                n_esc = 1'b0;
            end else if (ch == sicc_pkg::CH_BSLASH && !r_sq) begin
                n_esc = 1'b1;
            end else if (ch == sicc_pkg::CH_SQUOTE && !r_dq) begin
                n_sq = !r_sq;
            end else if (ch == sicc_pkg::CH_DQUOTE && !r_sq) begin
                n_dq = !r_dq;
            end else if (!r_sq && !r_dq) begin
                case (ch)
                    sicc_pkg::CH_LPAREN: begin
                        lv = lvl_add(r_paren, 1'b1);
                        n_paren = lv.val;
                    end
                    sicc_pkg::CH_RPAREN: begin
                        lv = lvl_add(r_paren, 1'b0);
                        n_paren = lv.val;
                    end
                    sicc_pkg::CH_LBRACE: begin
                        lv = lvl_add(r_brace, 1'b1);
                        n_brace = lv.val;
                    end
                    sicc_pkg::CH_RBRACE: begin
                        lv = lvl_add(r_brace, 1'b0);
                        n_brace = lv.val;
                    end
                    default: ;
                endcase
            end
        end
        n_seen = n_seen | lv.sat;

        // token builder; a space closes the token built so far
        if (c_space) begin
            n_chars = '0;
            n_len   = '0;
            n_phase = PH_LEAD;
        end else if (i_step.has_char && c_ws) begin
            if (r_phase == PH_WORD) n_phase = PH_TRAIL;
        end else if (i_step.has_char) begin
            case (r_phase)
                PH_LEAD: begin
                    n_chars = {24'd0, ch};
                    n_len   = 3'd1;
                    n_phase = PH_WORD;
                end
                PH_WORD: begin
                    if (r_len[2]) begin
                        n_phase = PH_DEAD;
                    end else begin
                        n_chars[r_len[1:0]*8 +: 8] = ch;
                        n_len = r_len + 3'd1;
                    end
                end
                default: n_phase = PH_DEAD;
            endcase
        end

        do_fin  = c_space || i_step.last;
        f_chars = c_space ? r_chars : n_chars;
        f_len   = c_space ? r_len   : n_len;
        f_phase = c_space ? r_phase : n_phase;

        lv = '0;
        if (do_fin && (f_phase == PH_WORD || f_phase == PH_TRAIL)) begin
            if (f_len == 3'd2) begin
                if (f_chars == sicc_pkg::KW_DO) begin
                    lv = lvl_add(r_loop, 1'b1);
                    n_loop = lv.val;
                end else if (f_chars == sicc_pkg::KW_IF) begin
                    lv = lvl_add(r_cond, 1'b1);
                    n_cond = lv.val;
                end else if (f_chars == sicc_pkg::KW_FI) begin
                    lv = lvl_add(r_cond, 1'b0);
                    n_cond = lv.val;
                end
            end else if (f_len == 3'd4) begin
                if (f_chars == sicc_pkg::KW_DONE) begin
                    lv = lvl_add(r_loop, 1'b0);
                    n_loop = lv.val;
                end else if (f_chars == sicc_pkg::KW_CASE) begin
                    lv = lvl_add(r_case, 1'b1);
                    n_case = lv.val;
                end else if (f_chars == sicc_pkg::KW_ESAC) begin
                    lv = lvl_add(r_case, 1'b0);
                    n_case = lv.val;
                end
            end
        end
        n_seen = n_seen | lv.sat;

        o_result.complete = !(n_sq || n_dq
            || n_paren > sicc_pkg::t_level'(0) || n_brace > sicc_pkg::t_level'(0)
            || n_loop > sicc_pkg::t_level'(0) || n_cond > sicc_pkg::t_level'(0)
            || n_case > sicc_pkg::t_level'(0));
        o_result.saturated = n_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step.fire && i_step.last)) begin
            r_esc   <= 1'b0;
            r_sq    <= 1'b0;
            r_dq    <= 1'b0;
            r_paren <= '0;
            r_brace <= '0;
            r_chars <= '0;
            r_len   <= '0;
            r_phase <= PH_LEAD;
            r_loop  <= '0;
            r_cond  <= '0;
            r_case  <= '0;
            r_seen  <= 1'b0;
        end else if (i_step.fire) begin
            r_esc   <= n_esc;
            r_sq    <= n_sq;
            r_dq    <= n_dq;
            r_paren <= n_paren;
            r_brace <= n_brace;
            r_chars <= n_chars;
            r_len   <= n_len;
            r_phase <= n_phase;
            r_loop  <= n_loop;
            r_cond  <= n_cond;
            r_case  <= n_case;
            r_seen  <= n_seen;
        end
    end

endmodule

/* design/shell_input_completeness_check.sv */
// Top level of the shell input completeness check: stream handshakes,
// input register and result register. Depends on sicc_pkg and sicc_state.

// Usage
//   Slave stream: one byte of command text per transaction. s_axis_tdata holds
//   the byte, s_axis_tuser says whether the byte is present (0 lets a bare end
//   mark close a text), s_axis_tlast marks the end of the text.
//   Master stream: one transaction per text, issued only for the transaction
//   that carried tlast. m_axis_tdata[0] is 1 when the text is a complete
//   command and 0 when it needs a continuation line; m_axis_tuser is 1 when any
//   bracket depth or do/if/case balance hit its signed limit in that text.
//   Transactions without tlast produce nothing on the master side.
// Timing
//   One byte per cycle sustained, except that a byte with tlast waits while a
//   verdict is held on a stalled master side. A byte sits in the input register
//   while the scan state updates; the verdict lands in the result register as
//   the last byte leaves the input register. The scan state update sets the rate.
// Reset and stalls
//   i_rst_n (synchronous, active low) empties both registers and clears all
//   scan state; the state also clears itself after each verdict. While the
//   master side stalls with a verdict held, bytes without tlast keep flowing;
//   a byte with tlast waits in the input register and s_axis_tready drops.

module shell_input_completeness_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic       s_axis_tuser,   // [0] has_char
    input  logic       s_axis_tlast,   // end of command text
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [0] complete, [7:1] zero
    output logic       m_axis_tuser    // [0] saturated
);

    logic              r_in_vld;
    logic [7:0]        r_in_char;
    logic              r_in_has;
    logic              r_in_last;
    logic              r_out_vld;
    sicc_pkg::t_result r_out;

    logic              adv;
    sicc_pkg::t_step   step;
    sicc_pkg::t_result res;

    // the input register moves on unless it holds an end byte while the
    // result register is occupied and m_axis_tready is low
    assign adv = r_in_vld && (!r_in_last || !r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;

    assign step.fire      = adv;
    assign step.char_code = r_in_char;
    assign step.has_char  = r_in_has;
    assign step.last      = r_in_last;

    sicc_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
            r_in_has  <= s_axis_tuser;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'd0, r_out.complete};
    assign m_axis_tuser  = r_out.saturated;

    // an end byte never overtakes a verdict that is still waiting
    a_end_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_in_last && r_out_vld && !m_axis_tready) |-> !s_axis_tready)
        else $error("end byte advanced over a held verdict");

    // a fresh verdict only follows an end byte leaving the input register
    a_verdict_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(adv && r_in_last))
        else $error("verdict appeared without an end byte");

    // back-to-back verdicts need an end byte each cycle
    a_verdict_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> (m_axis_tvalid == $past(adv && r_in_last)))
        else $error("result register refill mismatch");

endmodule

/* test/shell_input_completeness_check_tb.sv */
// Testbench for shell_input_completeness_check: streams command texts byte by
// byte, predicts each verdict in a local scanner model and checks every result.
// Depends on sicc_pkg and the shell_input_completeness_check RTL.

module shell_input_completeness_check_tb;
    import sicc_pkg::*;

    // Token tracker phases.
    typedef enum logic [1:0] {
        TOK_LEAD  = 2'd0,   // leading whitespace, no byte yet
        TOK_WORD  = 2'd1,   // collecting bytes
        TOK_TRAIL = 2'd2,   // whitespace after the word
        TOK_DEAD  = 2'd3    // can no longer match a keyword
    } t_tok_phase;

    localparam bit LVL_UP   = 1'b1;
    localparam bit LVL_DOWN = 1'b0;

    localparam logic [7:0] CH_TAB = 8'h09;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;  // [7:0] char_code
    logic       s_axis_tuser = 1'b0;   // [0] has_char
    logic       s_axis_tlast = 1'b0;   // end of command text
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [0] complete, [7:1] zero
    logic       m_axis_tuser;          // [0] saturated

    shell_input_completeness_check DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Scanner model: mirror of the quote/bracket scan, the token splitter
    // and the keyword balances. Updated once per accepted transaction.
    // ------------------------------------------------------------------
    logic       esc_pending, in_squote, in_dquote;
    t_level     paren_lvl, brace_lvl;
    t_level     loop_bal, cond_bal, case_bal;
    logic       sat_seen;
    logic [31:0] tok_chars;
    logic [2:0]  tok_len;
    t_tok_phase  tok_phase;

    t_result pending_verdicts[$];   // verdicts owed by the DUT, oldest first
    int      errors = 0;
    int      items_sent = 0;        // transactions carrying a byte or an end mark
    bit      send_gaps = 1'b0;
    bit      recv_stalls = 1'b0;
    int      stall_left = 0;
    logic [7:0] text_buf[$];        // text under construction

    function automatic void clear_scan();
        esc_pending = 1'b0;
        in_squote   = 1'b0;
        in_dquote   = 1'b0;
        paren_lvl   = '0;
        brace_lvl   = '0;
        loop_bal    = '0;
        cond_bal    = '0;
        case_bal    = '0;
        sat_seen    = 1'b0;
        tok_chars   = '0;
        tok_len     = '0;
        tok_phase   = TOK_LEAD;
    endfunction

    // Saturating step; hitting either rail only raises the flag.
    function automatic t_level step_level(input t_level lvl, input bit up);
        if (up) begin
            if (lvl == LVL_MAX) begin
                sat_seen = 1'b1;
                return lvl;
            end
            return lvl + t_level'(1);
        end
        if (lvl == LVL_MIN) begin
            sat_seen = 1'b1;
            return lvl;
        end
        return lvl - t_level'(1);
    endfunction

    function automatic void close_token();
        if (tok_phase == TOK_WORD || tok_phase == TOK_TRAIL) begin
            if (tok_len == 3'd2) begin
                if (tok_chars == KW_DO) loop_bal = step_level(loop_bal, LVL_UP);
                else if (tok_chars == KW_IF) cond_bal = step_level(cond_bal, LVL_UP);
                else if (tok_chars == KW_FI) cond_bal = step_level(cond_bal, LVL_DOWN);
            end else if (tok_len == 3'd4) begin
                if (tok_chars == KW_DONE) loop_bal = step_level(loop_bal, LVL_DOWN);
                else if (tok_chars == KW_CASE) case_bal = step_level(case_bal, LVL_UP);
                else if (tok_chars == KW_ESAC) case_bal = step_level(case_bal, LVL_DOWN);
            end
        end
        tok_chars = '0;
        tok_len   = '0;
        tok_phase = TOK_LEAD;
    endfunction

    // Token splitting ignores quotes and escapes entirely.
    function automatic void split_byte(input logic [7:0] c);
        if (c == CH_SPACE) begin
            close_token();
            return;
        end
        if (c >= CH_WS_LO && c <= CH_WS_HI) begin
            if (tok_phase == TOK_WORD) tok_phase = TOK_TRAIL;
            return;
        end
        case (tok_phase)
            TOK_LEAD: begin
                tok_chars = {24'h0, c};
                tok_len   = 3'd1;
                tok_phase = TOK_WORD;
            end
            TOK_WORD: begin
                if (tok_len >= 3'd4) begin
                    tok_phase = TOK_DEAD;
                end else begin
                    tok_chars = tok_chars | ({24'h0, c} << (8 * tok_len));
                    tok_len   = tok_len + 3'd1;
                end
            end
            default: tok_phase = TOK_DEAD;
        endcase
    endfunction

    function automatic void scan_quotes(input logic [7:0] c);
        if (esc_pending) begin
            esc_pending = 1'b0;
        end else if (c == CH_BSLASH && !in_squote) begin
            esc_pending = 1'b1;
        end else if (c == CH_SQUOTE && !in_dquote) begin
            in_squote = ~in_squote;
        end else if (c == CH_DQUOTE && !in_squote) begin
            in_dquote = ~in_dquote;
        end else if (!in_squote && !in_dquote) begin
            if (c == CH_LPAREN) paren_lvl = step_level(paren_lvl, LVL_UP);
            else if (c == CH_RPAREN) paren_lvl = step_level(paren_lvl, LVL_DOWN);
            else if (c == CH_LBRACE) brace_lvl = step_level(brace_lvl, LVL_UP);
            else if (c == CH_RBRACE) brace_lvl = step_level(brace_lvl, LVL_DOWN);
        end
    endfunction

    // Apply one accepted transaction; an end mark queues the verdict.
    function automatic void advance_scan(input logic [7:0] c, input logic has,
                                         input logic fin);
        t_result v;
        logic    open_text;
        if (has) begin
            scan_quotes(c);
            split_byte(c);
        end
        if (!fin) return;
        close_token();
        open_text = in_squote || in_dquote || paren_lvl > 0 || brace_lvl > 0
                    || loop_bal > 0 || cond_bal > 0 || case_bal > 0;
        v.complete  = !open_text;
        v.saturated = sat_seen;
        pending_verdicts.push_back(v);
        clear_scan();
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    // ------------------------------------------------------------------
    // Master side: random backpressure, and the verdict checker.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= gap_len();
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_verdicts.size() == 0) begin
                $error("unexpected verdict transaction: complete %0b saturated %0b",
                       m_axis_tdata[0], m_axis_tuser);
                errors++;
            end else begin
                want = pending_verdicts.pop_front();
                // tdata padding bits above 'complete' must stay zero
                if (m_axis_tdata !== {7'd0, want.complete}) begin
                    $error("complete mismatch: expected %0b, actual %b",
                           want.complete, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== want.saturated) begin
                    $error("saturated mismatch: expected %0b, actual %b",
                           want.saturated, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Slave side driver. Entered and left at a rising edge; the byte is
    // modeled at the edge where the transaction completes.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [7:0] c, input logic has, input logic fin);
        int gap;
        gap = send_gaps ? gap_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= has;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        advance_scan(c, has, fin);
        if (has || fin) items_sent++;
    endtask

    // Send a string; either the last byte carries the end mark or a bare
    // end-mark transaction follows.
    task automatic send_text(input string s, input bit bare_end);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b1, !bare_end && i == s.len() - 1);
        if (bare_end) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // Send text_buf as one text, with the odd ignored transaction mixed in.
    task automatic send_buffer();
        bit bare_end;
        bare_end = text_buf.size() == 0 || $urandom_range(0, 3) == 0;
        for (int i = 0; i < text_buf.size(); i++) begin
            if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(text_buf[i], 1'b1, !bare_end && i == text_buf.size() - 1);
        end
        if (bare_end) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Text generators
    // ------------------------------------------------------------------
    string openers[6] = '{"do", "if", "case", "(", "{", "$("};
    string closers[6] = '{"done", "fi", "esac", ")", "}", ")"};
    string fillers[16] = '{"x", "ls", "echo", "dox", "then", "esacx", "\"do\"",
                           "'a b'", "a\\ b", "$(ls)", "${v}", "done;", "cased",
                           "\\(", "|", "'it''s'"};
    logic [7:0] specials[9] = '{CH_SPACE, CH_TAB, CH_SQUOTE, CH_DQUOTE, CH_BSLASH,
                                CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE};

    // Word plus separator; separators with no space glue words into one token.
    task automatic add_word(input string w);
        int r;
        for (int i = 0; i < w.len(); i++) text_buf.push_back(w[i]);
        r = $urandom_range(0, 99);
        if (r < 75) text_buf.push_back(CH_SPACE);
        else if (r < 83) begin
            text_buf.push_back(CH_TAB);
            text_buf.push_back(CH_SPACE);
        end else if (r < 91) text_buf.push_back(8'($urandom_range(CH_WS_LO, CH_WS_HI)));
        else begin
            text_buf.push_back(CH_SPACE);
            text_buf.push_back(CH_SPACE);
        end
    endtask

    // Balanced nesting of keyword pairs, brackets and filler words.
    task automatic add_block(input int nest);
        int n, p;
        n = $urandom_range(1, 3);
        repeat (n) begin
            if (nest < 3 && $urandom_range(0, 9) < 5) begin
                p = $urandom_range(0, 5);
                add_word(openers[p]);
                add_block(nest + 1);
                add_word(closers[p]);
            end else begin
                add_word(fillers[$urandom_range(0, 15)]);
            end
        end
    endtask

    task automatic build_noise();
        int    n, r;
        string letters;
        letters = "doneifcas";
        n = $urandom_range(1, 12);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 40) text_buf.push_back(8'($urandom));
            else if (r < 70) text_buf.push_back(specials[$urandom_range(0, 8)]);
            else text_buf.push_back(letters[$urandom_range(0, 8)]);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_item(8'($urandom), 1'b0, 1'b1);  // empty text: bare end mark
        send_item(8'hA5, 1'b0, 1'b0);         // no byte, no end: ignored
        send_text("(", 1'b0);                 // open paren
        send_text("do", 1'b1);                // keyword closed by a bare end mark
        send_text("\\", 1'b0);                // backslash as final byte
        send_text(")", 1'b0);                 // closer without opener
        send_text("\tif\v", 1'b0);            // keyword trimmed of whitespace
        send_text("'\"", 1'b0);               // double quote inside single quotes
        send_item(8'hFF, 1'b1, 1'b0);         // byte extremes
        send_item(8'h00, 1'b1, 1'b1);
        send_text("esac", 1'b0);              // balance goes negative
        send_text("{", 1'b0);
        send_text("if\tfi", 1'b0);            // whitespace inside a token
    endtask

    // Push each kind of counter into its rails; 127 openers is the last
    // count that fits without saturating.
    task automatic test_saturation();
        for (int i = 0; i < 127; i++) send_item(CH_LPAREN, 1'b1, i == 126);
        for (int i = 0; i < 130; i++) send_item(CH_LPAREN, 1'b1, i == 129);
        for (int i = 0; i < 130; i++) send_item(CH_RBRACE, 1'b1, i == 129);
        for (int i = 0; i < 130; i++) begin
            send_item("d", 1'b1, 1'b0);
            send_item("o", 1'b1, 1'b0);
            send_item(CH_SPACE, 1'b1, 1'b0);
        end
        send_item(8'h00, 1'b0, 1'b1);
    endtask

    // Mostly well-formed texts with random content, some damaged, some noise.
    task automatic test_random_texts(input int count);
        int goal, r, k;
        goal = items_sent + count;
        while (items_sent < goal) begin
            text_buf.delete();
            if ($urandom_range(0, 7) == 0) text_buf.push_back(CH_TAB);
            r = $urandom_range(0, 99);
            if (r < 70) begin
                add_block(0);
            end else if (r < 85) begin
                add_block(0);
                k = $urandom_range(0, 2);
                if (k == 0) begin
                    repeat ($urandom_range(1, text_buf.size() - 1))
                        text_buf.delete(text_buf.size() - 1);
                end else if (k == 1) begin
                    text_buf.delete($urandom_range(0, text_buf.size() - 1));
                end else begin
                    text_buf.insert($urandom_range(0, text_buf.size()),
                                    specials[$urandom_range(0, 8)]);
                end
            end else begin
                build_noise();
            end
            send_buffer();
        end
    endtask

    initial begin
        clear_scan();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        test_directed();

        // back-to-back stretch on both sides
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        test_saturation();
        test_random_texts(100);

        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        test_random_texts(350);

        // sender flat out against a stalling receiver, then the reverse
        send_gaps = 1'b0;
        test_random_texts(150);
        send_gaps   = 1'b1;
        recv_stalls = 1'b0;
        test_random_texts(150);

        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #6000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
